// ===== hdl/blake3_single_chunk_hash_assert.svh =====
// Assertion macros for the single-chunk hash block.
// Used by the port checker; no other dependencies.
`ifndef BLAKE3_SINGLE_CHUNK_HASH_ASSERT_SVH
`define BLAKE3_SINGLE_CHUNK_HASH_ASSERT_SVH
`define B3_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define B3_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hdl/b3sch_pkg.sv =====
// Shared types, constants and functions for the single-chunk hash block.
// No dependencies.
`timescale 1ns / 1ps
package b3sch_pkg;
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int MAX_MESSAGE_BYTES_DEF = 1024;
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic [31:0] FLAG_BEGIN = 32'd1;
  localparam logic [31:0] FLAG_FINISH = 32'd2;
  localparam logic [31:0] FLAG_TOP = 32'd8;
  localparam logic [31:0] IV [8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372,
    32'hA54FF53A, 32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
  localparam logic [3:0] MSG_ORDER [16] = '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0,
    4'd4, 4'd13, 4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    logic        too_long;
  } out_item_t;

  // One block job handed from the front to the back.
  typedef struct packed {
    logic [511:0] block;
    logic [6:0]   len;
    logic [31:0]  flags;
    logic         final_blk;
    logic         too_long;
  } job_t;

  typedef logic [15:0][31:0] state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Half of a G function: one add-xor-rotate pair on four words.
  function automatic logic [127:0] g_half(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d,
                                          input logic [31:0] x, input int r1,
                                          input int r2);
    logic [31:0] a2, b2, c2, d2;
    a2 = a + b + x;
    d2 = rotr(d ^ a2, r1);
    c2 = c + d2;
    b2 = rotr(b ^ c2, r2);
    g_half = {a2, b2, c2, d2};
  endfunction
endpackage

// ===== hdl/b3sch_front.sv =====
// Front: buffers message bytes, forms block jobs with flags and lengths.
// Depends on b3sch_pkg.
`timescale 1ns / 1ps
module b3sch_front #(
  parameter int BLOCK_BYTES = b3sch_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = b3sch_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b3sch_pkg::in_item_t in_item,
  output logic                job_valid,
  input  logic                job_stall,
  output b3sch_pkg::job_t     job
);
  import b3sch_pkg::*;
  localparam int TW = $clog2(MAX_MESSAGE_BYTES + 2);

  logic [511:0]  block_reg;
  logic [6:0]    fill_count;
  logic          chunk_started;
  logic [TW-1:0] byte_total;

  wire accept = in_valid && !in_stall;
  wire need_job = (in_item.operation == OP_FINISH) || (fill_count == 7'(BLOCK_BYTES));

  // A byte into a full buffer or a finish must first hand the block over.
  assign in_stall = (need_job && job_stall) || job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_reg <= '0;
      fill_count <= '0;
      chunk_started <= 1'b0;
      byte_total <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && !job_stall) job_valid <= 1'b0;
      if (accept) begin
        if (need_job) begin
          job_valid <= 1'b1;
          job.block <= block_reg;
          job.len <= fill_count;
          job.too_long <= (byte_total > TW'(MAX_MESSAGE_BYTES));
          if (in_item.operation == OP_FINISH) begin
            job.final_blk <= 1'b1;
            job.flags <= FLAG_FINISH | FLAG_TOP | (chunk_started ? 32'd0 : FLAG_BEGIN);
            block_reg <= '0;
            fill_count <= '0;
            chunk_started <= 1'b0;
            byte_total <= '0;
          end else begin
            job.final_blk <= 1'b0;
            job.flags <= chunk_started ? 32'd0 : FLAG_BEGIN;
            chunk_started <= 1'b1;
            block_reg <= {504'd0, in_item.data_byte};
            fill_count <= 7'd1;
          end
        end else begin
          block_reg[{fill_count[5:0], 3'b000} +: 8] <= in_item.data_byte;
          fill_count <= fill_count + 7'd1;
        end
        if (in_item.operation == OP_APPEND && byte_total <= TW'(MAX_MESSAGE_BYTES))
          byte_total <= byte_total + TW'(1);
      end
    end
  end
endmodule

// ===== hdl/b3sch_queue.sv =====
// Two-entry queue of block jobs between front and back.
// Depends on b3sch_pkg.
`timescale 1ns / 1ps
module b3sch_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  b3sch_pkg::job_t wr_job,
  output logic            rd_valid,
  input  logic            rd_stall,
  output b3sch_pkg::job_t rd_job
);
  import b3sch_pkg::*;
  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  wire do_wr = wr_valid && !wr_stall;
  wire do_rd = rd_valid && !rd_stall;
  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = slots[rd_ptr];
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

// ===== hdl/b3sch_back.sv =====
// Back: iterative compression, one half-G column/diagonal step per cycle,
// chaining value update and digest output. Depends on b3sch_pkg.
`timescale 1ns / 1ps
module b3sch_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_stall,
  input  b3sch_pkg::job_t      job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b3sch_pkg::out_item_t out_item
);
  import b3sch_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_RUN = 4'b0010, S_FIN = 4'b0100, S_OUT = 4'b1000
  } st_t;
  st_t st;
  state_t v;
  logic [15:0][31:0] m;
  logic [31:0] cv [8];
  logic [4:0]  step;  // 7 rounds x 4 half-steps
  logic [1:0]  step_in_round;
  logic        final_blk, too_long;
  logic [1:0]  widx;
  state_t v_next;
  logic [15:0][31:0] m_perm;

  assign step_in_round = step[1:0];

  // Half-steps: 0/1 columns (x then y), 2/3 diagonals.
  always_comb begin
    logic [127:0] r;
    int a, b, c, d;
    v_next = v;
    for (int g = 0; g < 4; g++) begin
      if (!step_in_round[1]) begin
        a = g; b = 4 + g; c = 8 + g; d = 12 + g;
      end else begin
        a = g; b = 4 + ((g + 1) % 4); c = 8 + ((g + 2) % 4); d = 12 + ((g + 3) % 4);
      end
      r = g_half(v[a], v[b], v[c], v[d],
                 m[(step_in_round[1] ? 8 : 0) + 2*g + int'(step_in_round[0])],
                 step_in_round[0] ? 8 : 16, step_in_round[0] ? 7 : 12);
      v_next[a] = r[127:96];
      v_next[b] = r[95:64];
      v_next[c] = r[63:32];
      v_next[d] = r[31:0];
    end
    for (int i = 0; i < 16; i++) m_perm[i] = m[MSG_ORDER[i]];
  end

  assign job_stall = (st != S_IDLE);
  assign out_valid = (st == S_OUT);
  assign out_item.digest_word = {cv[2*widx+1], cv[2*widx]};
  assign out_item.word_index = widx;
  assign out_item.last_word = (widx == 2'd3);
  assign out_item.too_long = too_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      step <= '0;
      widx <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= IV[i];
    end else begin
      unique case (st)
        S_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 8; i++) v[i] <= cv[i];
            for (int i = 0; i < 4; i++) v[8+i] <= IV[i];
            v[12] <= '0;
            v[13] <= '0;
            v[14] <= 32'(job.len);
            v[15] <= job.flags;
            m <= job.block;
            final_blk <= job.final_blk;
            too_long <= job.too_long;
            step <= '0;
            st <= S_RUN;
          end
        end
        S_RUN: begin
          v <= v_next;
          if (step_in_round == 2'd3) m <= m_perm;
          step <= step + 5'd1;
          if (step == 5'd27) st <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) cv[i] <= v[i] ^ v[i+8];
          widx <= '0;
          st <= final_blk ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_stall) begin
            widx <= widx + 2'd1;
            if (widx == 2'd3) begin
              for (int i = 0; i < 8; i++) cv[i] <= IV[i];
              st <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/blake3_single_chunk_hash.sv =====
// Top level of the single-chunk hash block.
// Depends on b3sch_pkg, b3sch_front, b3sch_queue, b3sch_back.
// Appended bytes are taken without a stall while the buffer has room; a byte
// after a full block and a finish request each hand a block to the
// compressor, and the front then stalls while that block moves into the
// queue. The compressor loads each block, runs 28 half-round steps of one
// shared four-lane G datapath, then feeds forward. A finish yields four
// digest requests after its block, one per cycle unless the receiver stalls.
`timescale 1ns / 1ps
module blake3_single_chunk_hash #(
  parameter int BLOCK_BYTES = b3sch_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = b3sch_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b3sch_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b3sch_pkg::out_item_t out_item
);
  import b3sch_pkg::*;
  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  b3sch_front #(.BLOCK_BYTES(BLOCK_BYTES), .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job));
  b3sch_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job));
  b3sch_back u_back (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .out_item);
endmodule

// ===== hdl/b3sch_checker.sv =====
// Port checker for the single-chunk hash block, bound to the top level.
// Depends on b3sch_pkg and blake3_single_chunk_hash_assert.svh.
`timescale 1ns / 1ps
`include "blake3_single_chunk_hash_assert.svh"
module b3sch_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input b3sch_pkg::out_item_t out_item
);
  import b3sch_pkg::*;
  wire out_go = out_valid && !out_stall;
  wire step_go = out_go && !out_item.last_word;
  wire [1:0] idx = out_item.word_index;
  wire last_ok = out_item.last_word == (idx == 2'd3);
  `B3_ASSERT_IMPL(last_matches_index, clk, rst, out_valid, last_ok)
  `B3_ASSERT_NEXT(index_advances, clk, rst, step_go, out_valid && idx == $past(idx) + 2'd1)
  `B3_ASSERT_NEXT(flag_steady, clk, rst, step_go, out_item.too_long == $past(out_item.too_long))
  `B3_ASSERT_NEXT(stall_holds, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
endmodule

bind blake3_single_chunk_hash b3sch_props u_checker (
  .clk, .rst, .out_valid, .out_stall, .out_item);
